@@ design/byte_range_sector_burst_splitter_top_macros.svh @@
// Assertion macros used by the splitter controller.
`ifndef BYTE_RANGE_SECTOR_BURST_SPLITTER_TOP_MACROS_SVH
`define BYTE_RANGE_SECTOR_BURST_SPLITTER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BRSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BRSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/brss_pkg.sv @@
// Shared widths, codes and controller/datapath interface types for the splitter.
package brss_pkg;

   localparam int POS_W     = 41;
   localparam int LEN_W     = 32;
   localparam int SEC_W     = 32;
   localparam int CNT_W     = 16;
   localparam int SKIP_W    = 16;
   localparam int SS_W      = 17;
   localparam int OFS_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int DIV_W     = 42;
   localparam int STEP_W    = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_OFFSET = 2'd2;

   localparam logic [SS_W-1:0]  SS_MAX    = 17'd65536;
   localparam logic [SS_W-1:0]  SS_RESET  = 17'd512;
   localparam logic [CNT_W-1:0] BL_RESET  = 16'd128;
   localparam logic [SS_W-1:0]  COPY_MAX  = 17'h1FFFF;

   typedef logic [1:0] div_op_type;

   localparam div_op_type DIV_OP_POS = 2'd0;
   localparam div_op_type DIV_OP_TOT = 2'd1;
   localparam div_op_type DIV_OP_CAP = 2'd2;

   typedef struct packed {
      logic       load_req;
      logic       div_start;
      div_op_type div_op;
      logic       save_pos;
      logic       save_tot;
      logic       save_cap;
      logic       calc;
      logic       emit_ok;
      logic       emit_err;
   } brss_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic len_zero;
      logic bad;
      logic last_burst;
      logic out_free;
   } brss_sts_type;

endpackage

@@ design/brss_div.sv @@
// Iterative unsigned divider, two quotient bits per cycle, left-aligned dividend.
module brss_div import brss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [STEP_W-1:0] steps,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [SS_W-1:0]   divisor,
   output logic              busy,
   output logic [DIV_W-1:0]  quotient,
   output logic [SKIP_W-1:0] remainder
);

   logic [DIV_W-1:0]  q_ff, q_in;
   logic [SKIP_W-1:0] r_ff, r_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   logic [SS_W-1:0] t1, t2, r1, r2;
   logic            ge1, ge2;

   always_comb begin
      t1  = {r_ff, q_ff[DIV_W-1]};
      ge1 = (t1 >= divisor);
      r1  = ge1 ? (t1 - divisor) : t1;
      t2  = {r1[SKIP_W-1:0], q_ff[DIV_W-2]};
      ge2 = (t2 >= divisor);
      r2  = ge2 ? (t2 - divisor) : t2;
   end

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIV_W-3:0], ge1, ge2};
         r_in   = r2[SKIP_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

@@ design/brss_dp.sv @@
// Splitter datapath: config registers, divider, burst arithmetic and output word register.
module brss_dp import brss_pkg::*; #(
   parameter int MAX_REQUEST_BYTES = 65536,
   parameter int MAX_BURSTS        = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  brss_cmd_type         cmd,
   output brss_sts_type         sts,
   input  logic [POS_W-1:0]     req_start_position,
   input  logic [LEN_W-1:0]     req_length,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SEC_W-1:0]     rsp_sector,
   output logic [CNT_W-1:0]     rsp_burst_sectors,
   output logic [SKIP_W-1:0]    rsp_skip_bytes,
   output logic [SS_W-1:0]      rsp_copy_bytes,
   output logic                 rsp_status,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int MRB_W      = $clog2(MAX_REQUEST_BYTES + 1);
   localparam int CAP_STEPS  = (MRB_W + 1) / 2;
   localparam int CAP_SHIFT  = DIV_W - 2 * CAP_STEPS;
   localparam int LIM_W      = CNT_W + $clog2(MAX_BURSTS + 1);
   localparam int POS_STEPS  = DIV_W / 2;
   localparam int TOT_W      = SKIP_W + 17;
   localparam int TOT_STEPS  = 17;
   localparam logic [DIV_W-1:0] CAP_DIVIDEND = DIV_W'(MAX_REQUEST_BYTES) << CAP_SHIFT;

   // config registers
   logic [SS_W-1:0]  ss_cfg_ff, ss_cfg_in;
   logic [CNT_W-1:0] bl_cfg_ff, bl_cfg_in;
   logic [OFS_W-1:0] po_cfg_ff, po_cfg_in;

   always_comb begin
      ss_cfg_in = ss_cfg_ff;
      bl_cfg_in = bl_cfg_ff;
      po_cfg_in = po_cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SECTOR_SIZE: ss_cfg_in = csr_wdata[SS_W-1:0];
            CSR_BURST_LIMIT: bl_cfg_in = csr_wdata[CNT_W-1:0];
            CSR_PART_OFFSET: po_cfg_in = csr_wdata[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ss_cfg_ff <= SS_RESET;
         bl_cfg_ff <= BL_RESET;
         po_cfg_ff <= '0;
      end else begin
         ss_cfg_ff <= ss_cfg_in;
         bl_cfg_ff <= bl_cfg_in;
         po_cfg_ff <= po_cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   logic [SS_W-1:0]  ss_eff;
   logic [CNT_W-1:0] bl_eff;

   always_comb begin
      if (ss_cfg_ff == '0) begin
         ss_eff = SS_W'(1);
      end else if (ss_cfg_ff > SS_MAX) begin
         ss_eff = SS_MAX;
      end else begin
         ss_eff = ss_cfg_ff;
      end
      bl_eff = (bl_cfg_ff == '0) ? CNT_W'(1) : bl_cfg_ff;
   end

   // request state
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic [SEC_W-1:0]  next_sector_ff, next_sector_in;
   logic [SEC_W-1:0]  sectors_left_ff, sectors_left_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MRB_W-1:0]  prod_ff, prod_in;

   // divider
   logic [DIV_W-1:0]  div_dividend, div_quo;
   logic [STEP_W-1:0] div_steps;
   logic [SKIP_W-1:0] div_rem;
   logic              div_busy;
   logic [DIV_W-1:0]  abs_pos;
   logic [TOT_W-1:0]  tot_sum;

   assign abs_pos = {1'b0, req_start_position} + {1'b0, po_cfg_ff, 9'b0};
   assign tot_sum = TOT_W'(div_rem) + TOT_W'(len_ff) + TOT_W'(ss_eff) - TOT_W'(1);

   always_comb begin
      case (cmd.div_op)
         DIV_OP_POS: begin
            div_dividend = abs_pos;
            div_steps    = STEP_W'(POS_STEPS);
         end
         DIV_OP_TOT: begin
            div_dividend = {1'b0, tot_sum, 8'b0};
            div_steps    = STEP_W'(TOT_STEPS);
         end
         DIV_OP_CAP: begin
            div_dividend = CAP_DIVIDEND;
            div_steps    = STEP_W'(CAP_STEPS);
         end
         default: begin
            div_dividend = abs_pos;
            div_steps    = STEP_W'(POS_STEPS);
         end
      endcase
   end

   brss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .steps     (div_steps),
      .dividend  (div_dividend),
      .divisor   (ss_eff),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // burst arithmetic
   logic [MRB_W-1:0]      q_cap;
   logic [LIM_W-1:0]      lim;
   logic [CNT_W+SS_W-1:0] prod_full;
   logic [MRB_W-1:0]      copy_raw, copy_clip;
   logic [SS_W-1:0]       copy_out;

   assign q_cap = div_quo[MRB_W-1:0];
   assign lim   = LIM_W'(cap_ff) * LIM_W'(MAX_BURSTS);

   always_comb begin
      cnt_in    = (sectors_left_ff < SEC_W'(cap_ff)) ? sectors_left_ff[CNT_W-1:0] : cap_ff;
      prod_full = cnt_in * ss_eff;
      prod_in   = prod_full[MRB_W-1:0];
      cap_in    = (32'(q_cap) < 32'(bl_eff)) ? CNT_W'(q_cap) : bl_eff;
      copy_raw  = prod_ff - MRB_W'(skip_ff);
      copy_clip = (LEN_W'(copy_raw) > bytes_left_ff) ? MRB_W'(bytes_left_ff) : copy_raw;
      copy_out  = (32'(copy_clip) > 32'(COPY_MAX)) ? COPY_MAX : SS_W'(copy_clip);
   end

   always_comb begin
      len_in          = len_ff;
      bytes_left_in   = bytes_left_ff;
      skip_in         = skip_ff;
      next_sector_in  = next_sector_ff;
      sectors_left_in = sectors_left_ff;
      if (cmd.load_req) begin
         len_in        = req_length;
         bytes_left_in = req_length;
      end
      if (cmd.save_pos) begin
         skip_in        = div_rem;
         next_sector_in = div_quo[SEC_W-1:0];
      end
      if (cmd.save_tot) begin
         sectors_left_in = div_quo[SEC_W-1:0];
      end
      if (cmd.emit_ok) begin
         bytes_left_in   = bytes_left_ff - LEN_W'(copy_clip);
         skip_in         = '0;
         next_sector_in  = next_sector_ff + SEC_W'(cnt_ff);
         sectors_left_in = sectors_left_ff - SEC_W'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      len_ff          <= len_in;
      bytes_left_ff   <= bytes_left_in;
      skip_ff         <= skip_in;
      next_sector_ff  <= next_sector_in;
      sectors_left_ff <= sectors_left_in;
      if (cmd.save_cap) begin
         cap_ff <= cap_in;
      end
      if (cmd.calc) begin
         cnt_ff  <= cnt_in;
         prod_ff <= prod_in;
      end
   end

   // output word register
   logic rsp_valid_ff, rsp_valid_in;
   logic [SEC_W-1:0]  sector_ff;
   logic [CNT_W-1:0]  burst_ff;
   logic [SKIP_W-1:0] skip_out_ff;
   logic [SS_W-1:0]   copy_ff;
   logic              status_ff, last_ff;

   always_comb begin
      if (cmd.emit_ok || cmd.emit_err) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ok) begin
         sector_ff   <= next_sector_ff;
         burst_ff    <= cnt_ff;
         skip_out_ff <= skip_ff;
         copy_ff     <= copy_out;
         status_ff   <= 1'b0;
         last_ff     <= sts.last_burst;
      end else if (cmd.emit_err) begin
         sector_ff   <= '0;
         burst_ff    <= '0;
         skip_out_ff <= '0;
         copy_ff     <= '0;
         status_ff   <= 1'b1;
         last_ff     <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sector        = sector_ff;
   assign rsp_burst_sectors = burst_ff;
   assign rsp_skip_bytes    = skip_out_ff;
   assign rsp_copy_bytes    = copy_ff;
   assign rsp_status        = status_ff;
   assign rsp_last          = last_ff;

   // status to controller
   assign sts.div_busy   = div_busy;
   assign sts.len_zero   = (req_length == '0);
   assign sts.bad        = (cap_ff == '0) || (sectors_left_ff > SEC_W'(lim));
   assign sts.last_burst = (sectors_left_ff == SEC_W'(cnt_ff));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

@@ design/brss_ctrl.sv @@
// Splitter controller: sequences the divides, the limit check and the burst or error words.
`include "byte_range_sector_burst_splitter_top_macros.svh"
module brss_ctrl import brss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  brss_sts_type sts,
   output brss_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIVP  = 3'd1;
   localparam logic [2:0] ST_DIVT  = 3'd2;
   localparam logic [2:0] ST_DIVC  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_ERR   = 3'd5;
   localparam logic [2:0] ST_CALC  = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !sts.len_zero) begin
               cmd.load_req  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_OP_POS;
               state_in      = ST_DIVP;
            end
         end
         ST_DIVP: begin
            if (!sts.div_busy) begin
               cmd.save_pos  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_OP_TOT;
               state_in      = ST_DIVT;
            end
         end
         ST_DIVT: begin
            if (!sts.div_busy) begin
               cmd.save_tot  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_OP_CAP;
               state_in      = ST_DIVC;
            end
         end
         ST_DIVC: begin
            if (!sts.div_busy) begin
               cmd.save_cap = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = sts.bad ? ST_ERR : ST_CALC;
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_ok = 1'b1;
               state_in    = sts.last_burst ? ST_IDLE : ST_CALC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BRSS_ASSERT_NOW(a_start_idle_div, clock, reset, cmd.div_start, !sts.div_busy, "divider restarted while busy")
   `BRSS_ASSERT_NEXT(a_accept_divides, clock, reset, req_valid && req_ready && !sts.len_zero, sts.div_busy, "accepted request did not start divide")
   `BRSS_ASSERT_NEXT(a_last_to_idle, clock, reset, cmd.emit_ok && sts.last_burst, state_ff == ST_IDLE, "last burst word did not return to idle")
   `BRSS_ASSERT_NEXT(a_err_to_idle, clock, reset, cmd.emit_err, state_ff == ST_IDLE, "error word did not return to idle")

endmodule

@@ design/byte_range_sector_burst_splitter_top.sv @@
// Top level of the byte-range sector burst splitter.
//
// Request channel (req_*): one byte-range read, start position and length. A zero
// length is accepted and produces no word. Response channel (rsp_*): one word per
// sector burst with sector, sector count, skip bytes, copy bytes, status and last;
// a request needing too many bursts (or no burst fitting) gives one error word.
// Config channel (csr_*): index 0 sector size, 1 burst limit, 2 partition offset;
// always ready, write only while no request is in flight.
// One request is handled at a time. After acceptance the shared divider, two
// quotient bits per cycle, runs three divides in turn: the position, the sector
// total and the burst cap. The limit check then leads either to one error word
// or to the burst words, each prepared and then emitted, and the input stays
// held until the last word is emitted.
// A new request is taken as soon as the last word sits in the output register.
// If the receiver stalls, the word is held and bursting pauses until it is taken.
// Reset (synchronous) returns config to sector size 512, burst limit 128,
// offset 0, and empties the control path.
module byte_range_sector_burst_splitter_top import brss_pkg::*; #(
   parameter int MAX_REQUEST_BYTES = 65536,
   parameter int MAX_BURSTS        = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [POS_W-1:0]     req_start_position,
   input  logic [LEN_W-1:0]     req_length,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SEC_W-1:0]     rsp_sector,
   output logic [CNT_W-1:0]     rsp_burst_sectors,
   output logic [SKIP_W-1:0]    rsp_skip_bytes,
   output logic [SS_W-1:0]      rsp_copy_bytes,
   output logic                 rsp_status,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   brss_cmd_type cmd;
   brss_sts_type sts;

   brss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brss_dp #(
      .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
      .MAX_BURSTS        (MAX_BURSTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_start_position (req_start_position),
      .req_length         (req_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sector         (rsp_sector),
      .rsp_burst_sectors  (rsp_burst_sectors),
      .rsp_skip_bytes     (rsp_skip_bytes),
      .rsp_copy_bytes     (rsp_copy_bytes),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the byte-range sector burst splitter: directed table, then random reads.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import brss_pkg::*;

   localparam int MAX_REQUEST_BYTES = 65536;
   localparam int MAX_BURSTS        = 64;
   localparam int SETTLE_CYCLES     = 200;
   localparam int QUIET_LIMIT       = 20000;
   localparam int HOLD_CYCLES       = 1500;
   localparam int READS_PER_PHASE   = 54;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct packed {
      logic [SEC_W-1:0]  sector;
      logic [CNT_W-1:0]  burst_sectors;
      logic [SKIP_W-1:0] skip_bytes;
      logic [SS_W-1:0]   copy_bytes;
      logic              status;
      logic              last;
   } burst_word_type;

   typedef struct {
      logic [CSR_DAT_W-1:0] ss;
      logic [CSR_DAT_W-1:0] bl;
      logic [CSR_DAT_W-1:0] ofs;
      logic [POS_W-1:0]     pos;
      logic [LEN_W-1:0]     len;
      bit                   pin;
      burst_word_type       word;
   } read_row_type;

   localparam burst_word_type OVERRUN_WORD = '{32'd0, 16'd0, 16'd0, 17'd0, 1'b1, 1'b1};
   localparam burst_word_type ONE_BYTE_WORD = '{32'd0, 16'd1, 16'd0, 17'd1, 1'b0, 1'b1};
   localparam logic [POS_W-1:0] POS_TOP = {POS_W{1'b1}};
   localparam logic [LEN_W-1:0] LEN_TOP = {LEN_W{1'b1}};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [POS_W-1:0]     req_start_position;
   logic [LEN_W-1:0]     req_length;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [SEC_W-1:0]     rsp_sector;
   logic [CNT_W-1:0]     rsp_burst_sectors;
   logic [SKIP_W-1:0]    rsp_skip_bytes;
   logic [SS_W-1:0]      rsp_copy_bytes;
   logic                 rsp_status;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   // register mirror, updated on accepted writes
   logic [SS_W-1:0]  cfg_sector_size = SS_RESET;
   logic [CNT_W-1:0] cfg_burst_limit = BL_RESET;
   logic [OFS_W-1:0] cfg_part_offset = '0;

   burst_word_type pending_words[$];
   burst_word_type pinned_word;
   bit             pinned_on = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int rsp_hold       = 0;
   int quiet_cycles   = 0;
   int errors         = 0;
   int reads_taken    = 0;
   int empty_reads    = 0;
   int words_checked  = 0;
   int overrun_words  = 0;
   int csr_writes     = 0;
   int settings_used  = 0;

   int idle_plan[4]  = '{0, 84, 0, 26};
   int stall_plan[4] = '{0, 0, 84, 26};

   logic [CSR_DAT_W-1:0] applied_ss  = 32'd512;
   logic [CSR_DAT_W-1:0] applied_bl  = 32'd128;
   logic [CSR_DAT_W-1:0] applied_ofs = 32'd0;

   read_row_type read_rows[20];

   byte_range_sector_burst_splitter_top #(
      .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES),
      .MAX_BURSTS(MAX_BURSTS)
   ) uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] eff_sector_bytes();
      if (cfg_sector_size == '0) return 64'd1;
      if (cfg_sector_size > SS_MAX) return 64'(SS_MAX);
      return 64'(cfg_sector_size);
   endfunction

   function automatic logic [63:0] eff_burst_cap();
      logic [63:0] cap;
      logic [63:0] bl;
      cap = 64'(MAX_REQUEST_BYTES) / eff_sector_bytes();
      bl = (cfg_burst_limit == '0) ? 64'd1 : 64'(cfg_burst_limit);
      if (bl < cap) cap = bl;
      return cap;
   endfunction

   // Splits one byte-range read into the words the block should emit: burst words or one overrun word.
   function automatic void split_request(input logic [POS_W-1:0] pos,
                                         input logic [LEN_W-1:0] len);
      logic [63:0]      ss;
      logic [63:0]      cap;
      logic [63:0]      abs_pos;
      logic [63:0]      skip;
      logic [63:0]      sectors;
      logic [63:0]      owed;
      logic [63:0]      cnt;
      logic [63:0]      copy;
      logic [SEC_W-1:0] sec;
      burst_word_type   w;
      if (len == '0) return;
      ss = eff_sector_bytes();
      cap = eff_burst_cap();
      abs_pos = 64'(pos) + 64'(cfg_part_offset) * 64'd512;
      skip = abs_pos % ss;
      sec = SEC_W'(abs_pos / ss);
      sectors = (skip + 64'(len) + ss - 64'd1) / ss;
      owed = 64'(len);
      if (cap == 64'd0 || (sectors + cap - 64'd1) / cap > 64'(MAX_BURSTS)) begin
         pending_words.push_back(OVERRUN_WORD);
         return;
      end
      while (sectors != 64'd0) begin
         cnt = (sectors < cap) ? sectors : cap;
         copy = cnt * ss - skip;
         if (copy > owed) copy = owed;
         owed = owed - copy;
         sectors = sectors - cnt;
         w.sector = sec;
         w.burst_sectors = CNT_W'(cnt);
         w.skip_bytes = SKIP_W'(skip);
         w.copy_bytes = (copy > 64'(COPY_MAX)) ? COPY_MAX : SS_W'(copy);
         w.status = 1'b0;
         w.last = (sectors == 64'd0);
         pending_words.push_back(w);
         skip = 64'd0;
         sec = sec + SEC_W'(cnt);
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) flag_mismatch(what, got, want);
   endtask

   task automatic check_word();
      burst_word_type want;
      if (pending_words.size() == 0) begin
         flag_mismatch("unexpected word, sector", 64'(rsp_sector), 64'd0);
         return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (want.status) overrun_words++;
      check_field("sector", 64'(rsp_sector), 64'(want.sector));
      check_field("burst_sectors", 64'(rsp_burst_sectors), 64'(want.burst_sectors));
      check_field("skip_bytes", 64'(rsp_skip_bytes), 64'(want.skip_bytes));
      check_field("copy_bytes", 64'(rsp_copy_bytes), 64'(want.copy_bytes));
      check_field("status", 64'(rsp_status), 64'(want.status));
      check_field("last", 64'(rsp_last), 64'(want.last));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_SECTOR_SIZE: cfg_sector_size = csr_wdata[SS_W-1:0];
               CSR_BURST_LIMIT: cfg_burst_limit = csr_wdata[CNT_W-1:0];
               CSR_PART_OFFSET: cfg_part_offset = csr_wdata[OFS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            reads_taken++;
            if (req_length == '0) empty_reads++;
            if (pinned_on) begin
               pending_words.push_back(pinned_word);
               pinned_on = 1'b0;
            end else begin
               split_request(req_start_position, req_length);
            end
         end
         if (rsp_valid && rsp_ready) check_word();
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
      $display("byte_range_sector_burst_splitter_top test failed");
      $finish;
   end

   initial begin : receiver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic offer_read(input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_position <= pos;
      req_length <= len;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // lower valid, let every word come back, then give the block time to go idle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_splitter(input logic [CSR_DAT_W-1:0] ss,
                                   input logic [CSR_DAT_W-1:0] bl,
                                   input logic [CSR_DAT_W-1:0] ofs);
      write_csr(CSR_SECTOR_SIZE, ss);
      write_csr(CSR_BURST_LIMIT, bl);
      write_csr(CSR_PART_OFFSET, ofs);
      write_csr(CSR_UNUSED_IDX, $urandom);
      csr_valid <= 1'b0;
      applied_ss = ss;
      applied_bl = bl;
      applied_ofs = ofs;
      settings_used++;
   endtask

   // mostly reads that fit in the burst budget, plus empty, oversized and edge lengths
   task automatic run_reads(input int count);
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] len;
      logic [63:0]      ss;
      logic [63:0]      cap;
      logic [63:0]      max_ok;
      logic [63:0]      near;
      int               kind;
      int               sent;
      sent = 0;
      while (sent < count) begin
         ss = eff_sector_bytes();
         cap = eff_burst_cap();
         max_ok = 64'(MAX_BURSTS) * cap * ss - ss + 64'd1;
         near = (cap * ss * 64'd2 < max_ok) ? cap * ss * 64'd2 : max_ok;
         kind = $urandom_range(99);
         pos = POS_W'({$urandom, $urandom});
         if ($urandom_range(3) == 0) pos = POS_W'($urandom_range(4095));
         if (kind < 8)
            len = '0;
         else if (kind < 18)
            len = $urandom;
         else if (kind < 30)
            len = LEN_W'(max_ok - ss) + $urandom_range(0, 32'(ss * 64'd2));
         else if (kind < 65)
            len = $urandom_range(1, 32'(max_ok));
         else
            len = $urandom_range(1, 32'(near));
         offer_read(pos, len);
         if (len != '0) sent++;
      end
   endtask

   initial begin : stimulus
      logic [CSR_DAT_W-1:0] ss_w;
      logic [CSR_DAT_W-1:0] bl_w;
      logic [CSR_DAT_W-1:0] ofs_w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_start_position = '0;
      req_length = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      read_rows = '{
         '{32'd512, 32'd128, 32'd0, 41'd0, 32'd1, 1'b1, ONE_BYTE_WORD},
         '{32'd512, 32'd128, 32'd0, 41'd12345, 32'd0, 1'b0, '0},
         '{32'd512, 32'd128, 32'd0, 41'd100, 32'd512, 1'b0, '0},
         '{32'd512, 32'd128, 32'd0, POS_TOP, LEN_TOP, 1'b1, OVERRUN_WORD},
         '{32'd512, 32'd128, 32'd0, 41'd0, 32'd4194304, 1'b0, '0},
         '{32'd512, 32'd128, 32'd0, 41'd0, 32'd4194305, 1'b1, OVERRUN_WORD},
         '{32'd512, 32'd128, 32'd0, 41'h1FF_FFFF_FC00, 32'd2048, 1'b0, '0},
         '{32'd512, 32'd128, 32'd0, 41'd511, 32'd1, 1'b0, '0},
         '{32'd1, 32'd1, 32'd0, 41'd5, 32'd64, 1'b0, '0},
         '{32'd1, 32'd1, 32'd0, 41'd5, 32'd65, 1'b1, OVERRUN_WORD},
         '{32'd1, 32'd1, 32'd0, 41'h0_FFFF_FFFE, 32'd4, 1'b0, '0},
         '{32'd0, 32'd0, 32'd1, 41'd0, 32'd3, 1'b0, '0},
         '{32'd0, 32'd0, 32'd1, 41'd0, 32'd0, 1'b0, '0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 41'd0, 32'd1, 1'b0, '0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, POS_TOP, 32'd4128769, 1'b0, '0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 41'd1, LEN_TOP, 1'b1, OVERRUN_WORD},
         '{32'd3, 32'd7, 32'h8000_0000, 41'd2, 32'd100, 1'b0, '0},
         '{32'd3, 32'd7, 32'h8000_0000, 41'h155_5555_5555, 32'd1000, 1'b0, '0},
         '{32'd65536, 32'd2, 32'd128, 41'd65535, 32'd2, 1'b0, '0},
         '{32'd4096, 32'd3, 32'd7, 41'd77, 32'd40000, 1'b0, '0}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 26;
      recv_stall_pct = 26;
      foreach (read_rows[r]) begin
         if (read_rows[r].ss != applied_ss || read_rows[r].bl != applied_bl ||
             read_rows[r].ofs != applied_ofs) begin
            wait_quiet();
            program_splitter(read_rows[r].ss, read_rows[r].bl, read_rows[r].ofs);
         end
         pinned_word = read_rows[r].word;
         pinned_on = read_rows[r].pin;
         offer_read(read_rows[r].pos, read_rows[r].len);
      end

      for (int p = 0; p < 8; p++) begin
         wait_quiet();
         case ($urandom_range(7))
            0: ss_w = 32'd512;
            1: ss_w = 32'd4096;
            2: ss_w = 32'd1;
            3: ss_w = $urandom_range(2, 64);
            4: ss_w = $urandom_range(1, 65536);
            5: ss_w = 32'd65536;
            6: ss_w = $urandom;
            default: ss_w = $urandom_range(256, 2048);
         endcase
         case ($urandom_range(4))
            0: bl_w = $urandom_range(1, 4);
            1: bl_w = 32'd128;
            2: bl_w = $urandom_range(1, 65535);
            3: bl_w = 32'd0;
            default: bl_w = $urandom;
         endcase
         case ($urandom_range(2))
            0: ofs_w = 32'd0;
            1: ofs_w = $urandom_range(1, 4096);
            default: ofs_w = $urandom;
         endcase
         program_splitter(ss_w, bl_w, ofs_w);
         send_idle_pct = idle_plan[p % 4];
         recv_stall_pct = stall_plan[p % 4];
         run_reads(READS_PER_PHASE);
      end

      // receiver holds off while reads keep coming, so the input backs up
      wait_quiet();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      rsp_hold = HOLD_CYCLES;
      @(negedge clock);
      run_reads(24);

      wait_quiet();
      $display("covered %0d reads (%0d empty), %0d burst words checked, %0d overrun words",
               reads_taken, empty_reads, words_checked, overrun_words);
      $display("%0d register writes over %0d settings, four idle/stall mixes and a long hold",
               csr_writes, settings_used);
      if (errors == 0 && pending_words.size() == 0)
         $display("byte_range_sector_burst_splitter_top test passed");
      else
         $display("byte_range_sector_burst_splitter_top test failed");
      $finish;
   end

endmodule
